// ----- src/v2aa_pkg.sv -----
// Package for the vector-pair to axis-angle block: shared types and constants.
// Depends on nothing.
`timescale 1ns / 1ps
package v2aa_pkg;
    localparam int AXIS_W  = 16;
    localparam int ANGLE_W = 15;
    localparam logic [33:0] PI_Q30 = 34'd3373259426;
    localparam logic [14:0] PI_Q13 = 15'd25736;

    // Front-end product record queued for the back end.
    typedef struct packed {
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [33:0] cz;
        logic signed [34:0] dot;
    } prod_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0:  t = 32'h3243F6A8;  5'd1:  t = 32'h1DAC6705;
            5'd2:  t = 32'h0FADBAFC;  5'd3:  t = 32'h07F56EA6;
            5'd4:  t = 32'h03FEAB76;  5'd5:  t = 32'h01FFD55B;
            5'd6:  t = 32'h00FFFAAA;  5'd7:  t = 32'h007FFF55;
            5'd8:  t = 32'h003FFFEA;  5'd9:  t = 32'h001FFFFD;
            5'd10: t = 32'h000FFFFF;  5'd11: t = 32'h0007FFFF;
            5'd12: t = 32'h0003FFFF;  5'd13: t = 32'h0001FFFF;
            5'd14: t = 32'h0000FFFF;  5'd15: t = 32'h00007FFF;
            5'd16: t = 32'h00003FFF;  5'd17: t = 32'h00001FFF;
            5'd18: t = 32'h00000FFF;  5'd19: t = 32'h000007FF;
            5'd20: t = 32'h000003FF;  5'd21: t = 32'h000001FF;
            5'd22: t = 32'h000000FF;  5'd23: t = 32'h0000007F;
            5'd24: t = 32'h0000003F;  5'd25: t = 32'h0000001F;
            5'd26: t = 32'h0000000F;  5'd27: t = 32'h00000008;
            5'd28: t = 32'h00000004;  5'd29: t = 32'h00000002;
            5'd30: t = 32'h00000001;  default: t = 32'h00000000;
        endcase
        return t;
    endfunction
endpackage

// ----- src/v2aa_front.sv -----
// Front end: takes input beats, forms cross and dot products over two stages.
// Depends on v2aa_pkg.
`timescale 1ns / 1ps
module v2aa_front #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  logic [6*COMP_WIDTH-1:0] in_data,
    input  logic                    adv,
    output v2aa_pkg::prod_t         out_prod,
    output logic                    out_valid
);
    import v2aa_pkg::*;
    // drop the low bits of wide components; narrow ones are sign-extended
    localparam int SH = (COMP_WIDTH > 16) ? COMP_WIDTH - 16 : 0;

    logic signed [15:0] a [3];
    logic signed [15:0] b [3];
    logic signed [31:0] p_reg [9];
    logic signed [31:0] p_next [9];
    logic               v1_reg, v2_reg;
    prod_t              prod_reg, prod_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a[k] = 16'(signed'(in_data[k*COMP_WIDTH +: COMP_WIDTH]) >>> SH);
            b[k] = 16'(signed'(in_data[(k+3)*COMP_WIDTH +: COMP_WIDTH]) >>> SH);
        end
        // cross terms: ay*bz, az*by, az*bx, ax*bz, ax*by, ay*bx; dot terms
        p_next[0] = a[1] * b[2];  p_next[1] = a[2] * b[1];
        p_next[2] = a[2] * b[0];  p_next[3] = a[0] * b[2];
        p_next[4] = a[0] * b[1];  p_next[5] = a[1] * b[0];
        p_next[6] = a[0] * b[0];  p_next[7] = a[1] * b[1];
        p_next[8] = a[2] * b[2];
        prod_next.cx  = 34'(p_reg[0]) - 34'(p_reg[1]);
        prod_next.cy  = 34'(p_reg[2]) - 34'(p_reg[3]);
        prod_next.cz  = 34'(p_reg[4]) - 34'(p_reg[5]);
        prod_next.dot = 35'(p_reg[6]) + 35'(p_reg[7]) + 35'(p_reg[8]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        if (adv) begin
            p_reg    <= p_next;
            prod_reg <= prod_next;
        end
    end

    assign out_prod  = prod_reg;
    assign out_valid = v2_reg;
endmodule

// ----- src/v2aa_fifo.sv -----
// Short queue between front and back ends, with skid room for the pipeline.
// Depends on v2aa_pkg.
`timescale 1ns / 1ps
module v2aa_fifo #(
    parameter int DEPTH = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  v2aa_pkg::prod_t wr_data,
    input  logic            rd_en,
    output v2aa_pkg::prod_t rd_data,
    output logic            not_empty,
    output logic [$clog2(DEPTH):0] count
);
    import v2aa_pkg::*;
    localparam int AW = $clog2(DEPTH);

    prod_t         mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    assign rd_data   = mem_reg[rp_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;
endmodule

// ----- src/v2aa_back.sv -----
// Back end: normalize, square root, divide and CORDIC as a stalling pipeline.
// Depends on v2aa_pkg.
`timescale 1ns / 1ps
module v2aa_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  v2aa_pkg::prod_t in_prod,
    input  logic            adv,
    output logic [63:0]     out_data,
    output logic            out_valid
);
    import v2aa_pkg::*;
    localparam int CS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    // stages: 1 norm, 3 squares, 33 sqrt, 18 divide, CS+1 CORDIC, 1 finish

    typedef struct packed {
        logic        v;
        logic        deg;
        logic        dneg;
        logic [2:0]  sgn;
        logic [45:0] m0, m1, m2;   // scaled cross magnitudes (< 2^31)
        logic [61:0] xd;           // scaled dot magnitude
    } nrm_t;

    // ---------------- stage N: normalizing shift ----------------
    nrm_t n_reg, n_next;
    logic [33:0] mg [3];
    logic [34:0] dm;
    logic [33:0] mxv;
    logic [5:0]  lsh;
    always_comb begin
        mg[0] = in_prod.cx[33] ? 34'(-in_prod.cx) : 34'(in_prod.cx);
        mg[1] = in_prod.cy[33] ? 34'(-in_prod.cy) : 34'(in_prod.cy);
        mg[2] = in_prod.cz[33] ? 34'(-in_prod.cz) : 34'(in_prod.cz);
        dm    = in_prod.dot[34] ? 35'(-in_prod.dot) : 35'(in_prod.dot);
        mxv = mg[0];
        if (mg[1] > mxv) mxv = mg[1];
        if (mg[2] > mxv) mxv = mg[2];
        lsh = 6'd0;
        for (int k = 0; k < 31; k++)
            if (mxv[k]) lsh = 6'(30 - k);
        n_next.v    = in_valid;
        n_next.deg  = (mxv == '0);
        n_next.dneg = in_prod.dot[34];
        n_next.sgn  = {in_prod.cz[33], in_prod.cy[33], in_prod.cx[33]};
        n_next.m0   = 46'(mg[0]) << lsh;
        n_next.m1   = 46'(mg[1]) << lsh;
        n_next.m2   = 46'(mg[2]) << lsh;
        n_next.xd   = 62'(dm) << lsh;
    end

    // ---------------- square pipeline: 3 stages of partial products ----------
    typedef struct packed {
        nrm_t        n;
        logic [92:0] acc;
    } sq_t;
    sq_t q0_reg, q1_reg, q2_reg, q0_next, q1_next, q2_next;
    function automatic logic [92:0] sq_part(input logic [45:0] m);
        logic [22:0] lo, hi;
        lo = m[22:0]; hi = m[45:23];
        return (93'(hi * hi) << 46) + (93'(hi * lo) << 24) + 93'(lo * lo);
    endfunction
    always_comb begin
        q0_next.n = n_reg;  q0_next.acc = sq_part(n_reg.m0);
        q1_next.n = q0_reg.n; q1_next.acc = q0_reg.acc + sq_part(q0_reg.n.m1);
        q2_next.n = q1_reg.n; q2_next.acc = q1_reg.acc + sq_part(q1_reg.n.m2);
    end

    // ---------------- integer square root: one result bit per stage ----------
    localparam int SQ = 32;
    typedef struct packed {
        nrm_t        n;
        logic [63:0] rem;
        logic [63:0] root;
    } rt_t;
    rt_t rt_reg [SQ+1];
    rt_t rt_next [SQ+1];
    always_comb begin
        rt_next[0].n    = q2_reg.n;
        rt_next[0].rem  = 64'(q2_reg.acc);
        rt_next[0].root = '0;
        for (int s = 0; s < SQ; s++) begin
            rt_next[s+1] = rt_reg[s];
            if (rt_reg[s].rem >= rt_reg[s].root + (64'd1 << (62 - 2*s))) begin
                rt_next[s+1].rem  = rt_reg[s].rem
                                    - (rt_reg[s].root + (64'd1 << (62 - 2*s)));
                rt_next[s+1].root = (rt_reg[s].root >> 1) + (64'd1 << (62 - 2*s));
            end else begin
                rt_next[s+1].root = rt_reg[s].root >> 1;
            end
        end
    end

    // ---------------- divide: quotient bits by restoring steps ----------------
    typedef struct packed {
        nrm_t        n;
        logic [46:0] nn;
        logic [61:0] r0, r1, r2;
        logic [15:0] q0, q1, q2;
    } dv_t;
    localparam int DS = 16;
    dv_t dv_reg [DS+2];
    dv_t dv_next [DS+2];
    always_comb begin
        dv_next[0].n  = rt_reg[SQ].n;
        dv_next[0].nn = 47'(rt_reg[SQ].root);
        // numerator = m*16384 + n/2, quotient fits 15 bits (clamped to 16384)
        dv_next[0].r0 = 62'(rt_reg[SQ].n.m0) * 62'd16384 + 62'(rt_reg[SQ].root >> 1);
        dv_next[0].r1 = 62'(rt_reg[SQ].n.m1) * 62'd16384 + 62'(rt_reg[SQ].root >> 1);
        dv_next[0].r2 = 62'(rt_reg[SQ].n.m2) * 62'd16384 + 62'(rt_reg[SQ].root >> 1);
        dv_next[0].q0 = '0; dv_next[0].q1 = '0; dv_next[0].q2 = '0;
        for (int s = 0; s < DS; s++) begin
            logic [61:0] d;
            d = 62'(dv_reg[s].nn) << (DS-1-s);
            dv_next[s+1] = dv_reg[s];
            if (dv_reg[s].r0 >= d) begin
                dv_next[s+1].r0 = dv_reg[s].r0 - d; dv_next[s+1].q0[DS-1-s] = 1'b1;
            end
            if (dv_reg[s].r1 >= d) begin
                dv_next[s+1].r1 = dv_reg[s].r1 - d; dv_next[s+1].q1[DS-1-s] = 1'b1;
            end
            if (dv_reg[s].r2 >= d) begin
                dv_next[s+1].r2 = dv_reg[s].r2 - d; dv_next[s+1].q2[DS-1-s] = 1'b1;
            end
        end
        dv_next[DS+1] = dv_reg[DS];
    end

    // ---------------- CORDIC vectoring, one iteration per stage ----------------
    typedef struct packed {
        logic        v, deg, dneg;
        logic [47:0] axis;
        logic signed [43:0] x, y;
        logic signed [35:0] z;
    } cd_t;
    cd_t cd_reg [CS+1];
    cd_t cd_next [CS+1];
    function automatic logic [15:0] axc(input logic [15:0] q, input logic s);
        logic [15:0] c;
        c = (q > 16'd16384) ? 16'd16384 : q;
        return s ? 16'(-c) : c;
    endfunction
    always_comb begin
        logic [61:0] xs, ys, ov;
        logic [5:0]  rsh;
        xs = dv_reg[DS+1].n.xd;
        ys = 62'(dv_reg[DS+1].nn);
        // shift both right together until both are below 2^40
        ov  = xs | ys;
        rsh = 6'd0;
        for (int k = 40; k < 62; k++)
            if (ov[k]) rsh = 6'(k - 39);
        xs = xs >> rsh;
        ys = ys >> rsh;
        cd_next[0].v    = dv_reg[DS+1].n.v;
        cd_next[0].deg  = dv_reg[DS+1].n.deg;
        cd_next[0].dneg = dv_reg[DS+1].n.dneg;
        cd_next[0].axis = {axc(dv_reg[DS+1].q2, dv_reg[DS+1].n.sgn[2]),
                           axc(dv_reg[DS+1].q1, dv_reg[DS+1].n.sgn[1]),
                           axc(dv_reg[DS+1].q0, dv_reg[DS+1].n.sgn[0])};
        cd_next[0].x = 44'(xs);
        cd_next[0].y = 44'(ys);
        cd_next[0].z = '0;
        for (int s = 0; s < CS; s++) begin
            cd_next[s+1] = cd_reg[s];
            if (cd_reg[s].y > 0) begin
                cd_next[s+1].x = cd_reg[s].x + (cd_reg[s].y >>> s);
                cd_next[s+1].y = cd_reg[s].y - (cd_reg[s].x >>> s);
                cd_next[s+1].z = cd_reg[s].z + 36'(atan_q30(5'(s)));
            end else begin
                cd_next[s+1].x = cd_reg[s].x - (cd_reg[s].y >>> s);
                cd_next[s+1].y = cd_reg[s].y + (cd_reg[s].x >>> s);
                cd_next[s+1].z = cd_reg[s].z - 36'(atan_q30(5'(s)));
            end
        end
    end

    // ---------------- finish: pi fold, rounding, degenerate override ----------
    logic [63:0] fin_reg, fin_next;
    logic        fv_reg;
    always_comb begin
        logic signed [36:0] z;
        logic [36:0]        ang;
        cd_t                c;
        c = cd_reg[CS];
        z = (c.z < 0) ? '0 : 37'(c.z);
        if (c.dneg) z = 37'(PI_Q30) - z;
        if (z < 0) z = '0;
        ang = 37'((z + 37'sd65536) >>> 17);
        if (ang > 37'(PI_Q13)) ang = 37'(PI_Q13);
        fin_next = '0;
        if (c.deg) begin
            fin_next[62:48] = c.dneg ? PI_Q13 : 15'd0;
            fin_next[63]    = 1'b1;
        end else begin
            fin_next[47:0]  = c.axis;
            fin_next[62:48] = ang[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
            n_reg.v <= 1'b0;
            q0_reg.n.v <= 1'b0; q1_reg.n.v <= 1'b0; q2_reg.n.v <= 1'b0;
            for (int s = 0; s <= SQ; s++) rt_reg[s].n.v <= 1'b0;
            for (int s = 0; s < DS+2; s++) dv_reg[s].n.v <= 1'b0;
            for (int s = 0; s <= CS; s++) cd_reg[s].v <= 1'b0;
        end else if (adv) begin
            n_reg  <= n_next;
            q0_reg <= q0_next; q1_reg <= q1_next; q2_reg <= q2_next;
            rt_reg <= rt_next;
            dv_reg <= dv_next;
            cd_reg <= cd_next;
            fin_reg <= fin_next;
            fv_reg  <= cd_reg[CS].v;
        end
    end

    assign out_data  = fin_reg;
    assign out_valid = fv_reg;
endmodule

// ----- src/vectors_to_axis_angle.sv -----
// Top level: rotation between two vectors as unit axis and angle.
// Depends on v2aa_pkg, v2aa_front, v2aa_fifo, v2aa_back.
`timescale 1ns / 1ps
// Usage:
//   s_axis: one beat carries a vector pair, tdata = {pad, dst_z,dst_y,dst_x,
//   src_z,src_y,src_x}, COMP_WIDTH bits each, src_x lowest, zero pad to bytes.
//   m_axis: one beat per input beat, in order, tdata = {1'b0,
//   angle_rad[14:0], axis_z, axis_y, axis_x}, axis_x lowest; tuser carries
//   the degenerate flag.
//   Throughput: one pair per cycle sustained while the receiver takes results.
//   The front end (two product stages) runs into a queue; the back end is a
//   single pipeline of normalize, squares, bit-per-stage square root,
//   bit-per-stage divide and one CORDIC iteration per stage.
//   When the receiver stalls the back pipeline freezes and the queue fills;
//   s_axis_tready drops only when the queue cannot absorb the front stages.
//   Reset (aresetn low, synchronous) empties all stages and the queue.
//   Parallel, antiparallel or zero pairs give a zero axis and degenerate set.
module vectors_to_axis_angle #(
    parameter int COMP_WIDTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // src_x, src_y, src_z, dst_x, dst_y, dst_z from the lowest bit up
    input  logic [((6*COMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // axis_x, axis_y, axis_z, angle_rad from the lowest bit up
    output logic [63:0]             m_axis_tdata,
    // degenerate
    output logic                    m_axis_tuser
);
    import v2aa_pkg::*;

    localparam int QD = 8;
    prod_t       f_prod, q_prod;
    logic        f_valid, q_ne, f_adv, b_adv, b_valid, b_take;
    logic [$clog2(QD):0] q_cnt;
    logic [63:0] b_data;

    // Hold the front when the queue cannot take the items already in flight.
    assign f_adv         = (q_cnt <= ($clog2(QD)+1)'(QD - 3));
    assign s_axis_tready = f_adv;

    v2aa_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
        .aclk, .aresetn, .in_valid(s_axis_tvalid & s_axis_tready),
        .in_data(s_axis_tdata[6*COMP_WIDTH-1:0]), .adv(f_adv), .out_prod(f_prod),
        .out_valid(f_valid)
    );

    // Advance the back pipeline unless a finished beat is stuck at the output.
    assign b_adv  = !m_axis_tvalid || m_axis_tready;
    assign b_take = b_adv && q_ne;

    v2aa_fifo #(.DEPTH(QD)) u_fifo (
        .aclk, .aresetn, .wr_en(f_valid & f_adv), .wr_data(f_prod),
        .rd_en(b_take), .rd_data(q_prod), .not_empty(q_ne), .count(q_cnt)
    );

    v2aa_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk, .aresetn, .in_valid(b_take), .in_prod(q_prod), .adv(b_adv),
        .out_data(b_data), .out_valid(b_valid)
    );

    assign m_axis_tvalid = b_valid;
    assign m_axis_tdata  = {1'b0, b_data[62:0]};
    assign m_axis_tuser  = b_data[63];

`ifndef SYNTHESIS
    a_fifo_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt <= ($clog2(QD)+1)'(QD)) else $error("queue overflow");
    a_degen_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[47:0] == 48'd0)
        else $error("degenerate beat with nonzero axis");
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[62:48] <= PI_Q13) else $error("angle above pi");
`endif
endmodule

// ----- bench/v2aa_checker.sv -----
// Checker for vectors_to_axis_angle: watches both stream channels, predicts
// each result beat from the accepted input beat and compares field by field.
// Depends on v2aa_pkg.
`timescale 1ns / 1ps
module v2aa_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          fail_count,
    output int          pending
);
    import v2aa_pkg::*;

    typedef struct packed {
        logic        degenerate;
        logic [14:0] angle_rad;
        logic [15:0] axis_z;
        logic [15:0] axis_y;
        logic [15:0] axis_x;
    } rot_t;

    rot_t rot_q[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic rot_t predict_rotation(input logic [95:0] d);
        longint ax, ay, az, bx, by, bz, dotp, x, y, z, dx, dy, zang;
        longint c[3];
        logic [63:0] mag[3], mx, n, sum, xs, q;
        int sh;
        rot_t r;
        ax = longint'($signed(d[15:0]));  ay = longint'($signed(d[31:16]));
        az = longint'($signed(d[47:32])); bx = longint'($signed(d[63:48]));
        by = longint'($signed(d[79:64])); bz = longint'($signed(d[95:80]));
        c[0] = ay * bz - az * by;
        c[1] = az * bx - ax * bz;
        c[2] = ax * by - ay * bx;
        dotp = ax * bx + ay * by + az * bz;
        r = '0;
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            r.degenerate = 1'b1;
            r.angle_rad = (dotp < 0) ? PI_Q13 : 15'd0;
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (c[i] < 0) ? 64'(-c[i]) : 64'(c[i]);
            if (mag[i] > mx) mx = mag[i];
        end
        sh = 0;
        while ((mx << sh) < (64'd1 << 30)) sh++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = mag[i] << sh;
            sum = sum + mag[i] * mag[i];
        end
        n = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 64'd16384 + n / 2) / n;
            if (q > 16384) q = 16384;
            q = (c[i] < 0) ? -q : q;
            if (i == 0) r.axis_x = q[15:0];
            else if (i == 1) r.axis_y = q[15:0];
            else r.axis_z = q[15:0];
        end
        xs = ((dotp < 0) ? 64'(-dotp) : 64'(dotp)) << sh;
        while (xs >= (64'd1 << 40) || n >= (64'd1 << 40)) begin
            xs = xs >> 1;
            n = n >> 1;
        end
        x = longint'(xs);
        y = longint'(n);
        z = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
            end else begin
                x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
            end
        end
        if (z < 0) z = 0;
        if (dotp < 0) z = longint'(PI_Q30) - z;
        if (z < 0) z = 0;
        zang = (z + (64'sd1 <<< 16)) >>> 17;
        if (zang > longint'(PI_Q13)) zang = longint'(PI_Q13);
        r.angle_rad = zang[14:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        rot_t got, want;
        if (!aresetn) begin
            rot_q.delete();
            fail_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                rot_q.push_back(predict_rotation(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata[62:0]};
                if (rot_q.size() == 0) begin
                    $error("unexpected result beat %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = rot_q.pop_front();
                    if (got !== want || m_axis_tdata[63] !== 1'b0) begin
                        if (got.axis_x !== want.axis_x)
                            $error("axis_x exp %h got %h", want.axis_x, got.axis_x);
                        if (got.axis_y !== want.axis_y)
                            $error("axis_y exp %h got %h", want.axis_y, got.axis_y);
                        if (got.axis_z !== want.axis_z)
                            $error("axis_z exp %h got %h", want.axis_z, got.axis_z);
                        if (got.angle_rad !== want.angle_rad)
                            $error("angle_rad exp %0d got %0d",
                                   want.angle_rad, got.angle_rad);
                        if (got.degenerate !== want.degenerate)
                            $error("degenerate exp %b got %b",
                                   want.degenerate, got.degenerate);
                        if (m_axis_tdata[63] !== 1'b0)
                            $error("tdata pad exp 0 got %b", m_axis_tdata[63]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    assign pending = rot_q.size();
endmodule

// ----- bench/tb.sv -----
// Testbench top for vectors_to_axis_angle: drives vector-pair beats with
// random gaps and receiver stalls, and gives the verdict from v2aa_checker.
// Depends on v2aa_pkg, v2aa_checker and the block's RTL.
`timescale 1ns / 1ps
module tb;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          fail_count;
    int          pending;
    bit          stall_enable = 1'b1;

    always #10 aclk = ~aclk;

    vectors_to_axis_angle i_dut (.*);

    v2aa_checker i_checker (.*);

    // Mostly short gaps, now and then a long one; sometimes none at all.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [15:0] rand_comp();
        int p;
        p = $urandom_range(9);
        if (p == 0) return 16'h8000;
        if (p == 1) return 16'h7FFF;
        if (p < 4) return 16'($signed($urandom_range(8)) - 4);
        return 16'($urandom);
    endfunction

    // Hold the pair on the bus until accepted, then idle for a random gap.
    task automatic send_pair(input logic [95:0] pair);
        int g;
        s_axis_tdata  <= pair;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic logic [95:0] pack_pair(input logic [15:0] a0, a1, a2,
                                              b0, b1, b2);
        return {b2, b1, b0, a2, a1, a0};
    endfunction

    // Receiver: stall at random, with stretches of no stalling.
    initial begin
        int g;
        forever begin
            @(posedge aclk);
            if (stall_enable && $urandom_range(99) < 30) begin
                g = gap_len();
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(posedge aclk);
        end
    end

    initial begin
        logic [15:0] k, a0, a1, a2;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed: extremes, zero vectors, parallel and antiparallel pairs.
        send_pair('0);
        send_pair({48'h0, 16'h0, 16'h0, 16'h0005});
        send_pair(pack_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_pair(pack_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_pair(pack_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8001, 16'h8001, 16'h8001));
        send_pair(pack_pair(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_pair(pack_pair(16'd1, 16'd2, 16'd3, 16'd2, 16'd4, 16'd6));
        send_pair(pack_pair(16'd1, 16'd2, 16'd3, -16'sd3, -16'sd6, -16'sd9));
        send_pair(pack_pair(16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0));
        send_pair(pack_pair(16'd1, 16'd0, 16'd0, -16'sd1, 16'd1, 16'd0));
        send_pair(pack_pair(16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0));
        send_pair(pack_pair(16'h7FFF, 16'd0, 16'd0, 16'd0, 16'h8000, 16'd0));
        send_pair(pack_pair(16'h8000, 16'h7FFF, 16'd0, 16'h7FFF, 16'h8000, 16'h0001));
        send_pair(pack_pair(16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'h8000));
        send_pair(pack_pair(16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h8000));
        send_pair(pack_pair(16'h7FFF, 16'h7FFE, 16'd0, 16'h7FFE, 16'h7FFD, 16'd0));
        // Random: mostly independent pairs, some near-parallel ones.
        for (int i = 0; i < 850; i++) begin
            if ($urandom_range(9) == 0) begin
                a0 = rand_comp(); a1 = rand_comp(); a2 = rand_comp();
                k = 16'($signed($urandom_range(6)) - 3);
                send_pair(pack_pair(a0, a1, a2, 16'($signed(a0) * $signed(k)),
                                    16'($signed(a1) * $signed(k)),
                                    16'($signed(a2) * $signed(k)) ^
                                    16'($urandom_range(1))));
            end else begin
                send_pair(pack_pair(rand_comp(), rand_comp(), rand_comp(),
                                    rand_comp(), rand_comp(), rand_comp()));
            end
            if (i == 600) stall_enable = 1'b0;
            if (i == 700) stall_enable = 1'b1;
        end
        s_axis_tvalid <= 1'b0;
        // Drain: wait for every expected beat, then let the pipeline settle.
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
src/v2aa_pkg.sv
src/v2aa_front.sv
src/v2aa_fifo.sv
src/v2aa_back.sv
src/vectors_to_axis_angle.sv
bench/v2aa_checker.sv
bench/tb.sv
